### src/grdw_pkg.sv
// shared types and constants of the grid ray walker
package grdw_pkg;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	// map value that stops the walk
	localparam logic [3:0] CELL_WALL = 4'd2;

	// one map unit in Q1.10
	localparam logic [10:0] ONE_UNIT = 11'd1024;

	// shared unit operations
	localparam logic [1:0] ALU_CMP = 2'd0;
	localparam logic [1:0] ALU_MUL = 2'd1;
	localparam logic [1:0] ALU_ADD = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [3:0]  cell_value;
		logic [15:0] ray_pos_x;
		logic [15:0] ray_pos_y;
		logic        dir_x_negative;
		logic        dir_y_negative;
		logic [23:0] delta_dist_x;
		logic [23:0] delta_dist_y;
	} cmd_item_t;

	typedef struct packed {
		logic        hit_found;
		logic [5:0]  hit_cell_x;
		logic [5:0]  hit_cell_y;
		logic        hit_side;
		logic [31:0] final_side_x;
		logic [31:0] final_side_y;
		logic [7:0]  steps_taken;
	} res_item_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        lt;
	} alu_rsp_t;

endpackage

### src/grdw_ram.sv
// generic single write, single read ram with registered read data
module grdw_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/grdw_alu.sv
// shared arithmetic unit: span multiply, saturating add, compare
module grdw_alu
	import grdw_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [34:0] prod;
	logic [32:0] sum;

	assign prod = 35'(req.a[10:0]) * 35'(req.b[23:0]);
	assign sum  = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		rsp.lt = req.a < req.b;
		unique case (req.op)
			ALU_MUL: rsp.value = 32'(prod[34:10]);
			ALU_ADD: rsp.value = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			default: rsp.value = 32'd0;
		endcase
	end

endmodule

### src/grid_ray_dda_walker_core.sv
// grid ray walker top level: command handshake, walk sequencer, result register
//
// usage
//   cmd channel (cmd_valid, cmd_ready, cmd_item): one transfer is either a map
//   cell write (cmd = 0) or a ray cast (cmd = 1). cmd_ready is high only while
//   the sequencer is idle; a cast holds it low until its walk is finished.
//   res channel (res_valid, res_ready, res_item): one result per cast, none per
//   write. the result sits in an output register, so the next command can be
//   taken while a result still waits.
// sequence
//   a write leaves the sequencer idle, so the next command is taken right after.
//   a cast runs the setup multiplies (one shared multiplier, x then y), a compare,
//   then per grid step add and move, map read and wall test, then the result
//   load; a ray that starts outside the map goes from the multiplies to the load.
//   the map ram read port and the shared add/compare unit set the step time.
// reset
//   arst_n clears the sequencer and the result valid flag. map contents are
//   undefined until written.
// stall
//   if res_ready stays low, a finished cast waits in its last state until the
//   output register frees up; cmd_ready stays low meanwhile.
module grid_ray_dda_walker_core
	import grdw_pkg::*;
#(
	parameter int MAP_DIM   = 64,
	parameter int MAX_STEPS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd_item,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_item
);

	localparam int CW    = $clog2(MAP_DIM);
	localparam int XW    = (CW > 6) ? CW : 6;
	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [XW-1:0] LAST_CELL = XW'(MAP_DIM - 1);
	localparam logic [7:0]    STEP_MAX  = 8'(MAX_STEPS);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MULX  = 3'd1;
	localparam logic [2:0] ST_MULY  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_CHECK = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0] state_q;

	// walk state
	logic [XW-1:0] cur_x_q, cur_y_q;
	logic [31:0]   side_x_q, side_y_q;
	logic [1:0]    dir_q;          // bit 0: x steps down, bit 1: y steps down
	logic          axis_q;         // axis picked for the next step, 1 = y
	logic          last_axis_q;
	logic [7:0]    steps_q;
	logic          hit_q;
	logic [23:0]   dx_q, dy_q;
	logic [9:0]    fx_q, fy_q;

	logic      res_valid_q;
	res_item_t res_q;

	logic cmd_xfer;
	logic cast_xfer;
	logic start_in_map;
	logic step_leaves;
	logic res_load;

	logic [10:0] span_x, span_y;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [3:0]    ram_rdata;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd_valid & cmd_ready;
	assign cast_xfer = cmd_xfer & (cmd_item.cmd == CMD_CAST);

	// writes outside the map are dropped
	assign ram_we = cmd_xfer & (cmd_item.cmd == CMD_WRITE)
		& (32'(cmd_item.cell_x) < 32'(MAP_DIM)) & (32'(cmd_item.cell_y) < 32'(MAP_DIM));
	assign ram_waddr = AW'(32'(cmd_item.cell_y) * 32'(MAP_DIM) + 32'(cmd_item.cell_x));
	assign ram_raddr = AW'(32'(cur_y_q) * 32'(MAP_DIM) + 32'(cur_x_q));

	grdw_ram #(
		.WIDTH(4),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd_item.cell_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// distance from origin to first cell border, in Q1.10
	assign span_x = dir_q[0] ? {1'b0, fx_q} : ONE_UNIT - {1'b0, fx_q};
	assign span_y = dir_q[1] ? {1'b0, fy_q} : ONE_UNIT - {1'b0, fy_q};

	assign start_in_map = (32'(cur_x_q) < 32'(MAP_DIM)) & (32'(cur_y_q) < 32'(MAP_DIM));

	// the next step would leave the map on its axis
	always_comb begin
		if (axis_q) begin
			step_leaves = dir_q[1] ? (cur_y_q == '0) : (cur_y_q == LAST_CELL);
		end else begin
			step_leaves = dir_q[0] ? (cur_x_q == '0) : (cur_x_q == LAST_CELL);
		end
	end

	// operand selection for the shared unit
	always_comb begin
		alu_req.op = ALU_CMP;
		alu_req.a  = side_x_q;
		alu_req.b  = side_y_q;
		unique case (state_q)
			ST_MULX: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = 32'(span_x);
				alu_req.b  = 32'(dx_q);
			end
			ST_MULY: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = 32'(span_y);
				alu_req.b  = 32'(dy_q);
			end
			ST_STEP: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = axis_q ? side_y_q : side_x_q;
				alu_req.b  = axis_q ? 32'(dy_q) : 32'(dx_q);
			end
			default: begin
				alu_req.op = ALU_CMP;
			end
		endcase
	end

	grdw_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign res_load = (state_q == ST_OUT) & (~res_valid_q | res_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cast_xfer) begin
						state_q <= ST_MULX;
					end
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= start_in_map ? ST_CMP : ST_OUT;
				ST_CMP:  state_q <= ST_STEP;
				ST_STEP: state_q <= step_leaves ? ST_OUT : ST_READ;
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (ram_rdata == CELL_WALL || steps_q == STEP_MAX) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_OUT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cast_xfer) begin
					cur_x_q     <= XW'(cmd_item.ray_pos_x[15:10]);
					cur_y_q     <= XW'(cmd_item.ray_pos_y[15:10]);
					fx_q        <= cmd_item.ray_pos_x[9:0];
					fy_q        <= cmd_item.ray_pos_y[9:0];
					dir_q       <= {cmd_item.dir_y_negative, cmd_item.dir_x_negative};
					dx_q        <= cmd_item.delta_dist_x;
					dy_q        <= cmd_item.delta_dist_y;
					last_axis_q <= 1'b0;
					steps_q     <= 8'd0;
					hit_q       <= 1'b0;
				end
			end
			ST_MULX: side_x_q <= alu_rsp.value;
			ST_MULY: side_y_q <= alu_rsp.value;
			ST_CMP:  axis_q   <= ~alu_rsp.lt;     // tie steps in y
			ST_STEP: begin
				if (axis_q) begin
					side_y_q <= alu_rsp.value;
					if (!step_leaves) begin
						cur_y_q <= dir_q[1] ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
					end
				end else begin
					side_x_q <= alu_rsp.value;
					if (!step_leaves) begin
						cur_x_q <= dir_q[0] ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
					end
				end
				last_axis_q <= axis_q;
				steps_q     <= steps_q + 8'd1;
			end
			ST_READ: axis_q <= ~alu_rsp.lt;       // pick the next axis while the map is read
			ST_CHECK: begin
				if (ram_rdata == CELL_WALL) begin
					hit_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.hit_found    <= hit_q;
			res_q.hit_cell_x   <= cur_x_q[5:0];
			res_q.hit_cell_y   <= cur_y_q[5:0];
			res_q.hit_side     <= last_axis_q;
			res_q.final_side_x <= side_x_q;
			res_q.final_side_y <= side_y_q;
			res_q.steps_taken  <= steps_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

### sim/tb_grid_ray_dda_walker_core.sv
// self-checking testbench of the grid ray walker: map writes, ray casts and handshake stalls
module tb_grid_ray_dda_walker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import grdw_pkg::*;

	localparam int MAP_DIM     = 64;
	localparam int MAX_STEPS   = 128;
	localparam int MAP_CELLS   = MAP_DIM * MAP_DIM;
	// longest cast: setup, compare, per step add, map read and wall test, result load
	localparam int WALK_CYCLES = 4 + 3 * MAX_STEPS;
	localparam int CYCLE_LIMIT = 3_000_000;

	// axis of a grid step as reported in hit_side
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd_item  = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_item_t res_item;

	// predicted map contents and which cells have been written so far
	logic [3:0] map_cells [MAP_CELLS];
	bit         map_known [MAP_CELLS];
	res_item_t  pending_walks [$];

	int mismatch_count = 0;
	int items_sent     = 0;
	int send_gap_pct   = 0;
	int stall_pct      = 0;
	int hold_request   = 0;
	int hold_left      = 0;

	grid_ray_dda_walker_core #(
		.MAP_DIM  (MAP_DIM),
		.MAX_STEPS(MAX_STEPS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_item (cmd_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item (res_item)
	);

	initial forever #2 clk = ~clk;

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[grid_ray_dda_walker_core] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// initial side distance: fraction to the first grid line times the delta, Q16.16
	function automatic logic [31:0] first_side(logic [9:0] frac, logic neg, logic [23:0] delta);
		logic [10:0] span;
		logic [63:0] prod;
		span = neg ? {1'b0, frac} : ONE_UNIT - {1'b0, frac};
		prod = 64'(span) * 64'(delta);
		return prod[41:10];
	endfunction

	function automatic logic [31:0] side_add(logic [31:0] acc, logic [23:0] delta);
		logic [32:0] sum;
		sum = {1'b0, acc} + {9'b0, delta};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// walks one cast over the predicted map; returns the index of the first
	// never-written cell the walk would enter, or -1 when every read is defined
	function automatic int walk_ray(input cmd_item_t ray, output res_item_t res);
		logic [5:0]  cx, cy;
		logic [31:0] sx, sy;
		logic        axis, hit;
		int          nx, ny, n, idx, unknown;
		cx      = ray.ray_pos_x[15:10];
		cy      = ray.ray_pos_y[15:10];
		sx      = first_side(ray.ray_pos_x[9:0], ray.dir_x_negative, ray.delta_dist_x);
		sy      = first_side(ray.ray_pos_y[9:0], ray.dir_y_negative, ray.delta_dist_y);
		axis    = AXIS_X;
		hit     = 1'b0;
		n       = 0;
		unknown = -1;
		if (cx < MAP_DIM && cy < MAP_DIM) begin
			while (n < MAX_STEPS) begin
				nx = int'(cx);
				ny = int'(cy);
				// strictly smaller side wins, a tie goes to y
				if (sx < sy) begin
					sx   = side_add(sx, ray.delta_dist_x);
					nx   = ray.dir_x_negative ? nx - 1 : nx + 1;
					axis = AXIS_X;
				end else begin
					sy   = side_add(sy, ray.delta_dist_y);
					ny   = ray.dir_y_negative ? ny - 1 : ny + 1;
					axis = AXIS_Y;
				end
				n++;
				// leaving the map counts the step but keeps the last cell inside
				if (nx < 0 || ny < 0 || nx >= MAP_DIM || ny >= MAP_DIM)
					break;
				cx  = 6'(nx);
				cy  = 6'(ny);
				idx = ny * MAP_DIM + nx;
				if (!map_known[idx]) begin
					unknown = idx;
					break;
				end
				if (map_cells[idx] == CELL_WALL) begin
					hit = 1'b1;
					break;
				end
			end
		end
		res.hit_found    = hit;
		res.hit_cell_x   = cx;
		res.hit_cell_y   = cy;
		res.hit_side     = axis;
		res.final_side_x = sx;
		res.final_side_y = sy;
		res.steps_taken  = 8'(n);
		return unknown;
	endfunction

	// applies one accepted transfer to the predicted state
	function automatic void record_transfer(cmd_item_t it);
		res_item_t res;
		int        idx;
		if (it.cmd == CMD_WRITE) begin
			if (it.cell_x < MAP_DIM && it.cell_y < MAP_DIM) begin
				idx            = int'(it.cell_y) * MAP_DIM + int'(it.cell_x);
				map_cells[idx] = it.cell_value;
				map_known[idx] = 1'b1;
			end
		end else begin
			void'(walk_ray(it, res));
			pending_walks.push_back(res);
		end
	endfunction

	// ---------------------------------------------------------------- result side

	always @(posedge clk) begin : receiver
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_walks.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result transfer with none expected, got %h", $time, res_item);
			end else begin
				want = pending_walks.pop_front();
				check_field("hit_found", 32'(want.hit_found), 32'(res_item.hit_found));
				check_field("hit_cell_x", 32'(want.hit_cell_x), 32'(res_item.hit_cell_x));
				check_field("hit_cell_y", 32'(want.hit_cell_y), 32'(res_item.hit_cell_y));
				check_field("hit_side", 32'(want.hit_side), 32'(res_item.hit_side));
				check_field("final_side_x", want.final_side_x, res_item.final_side_x);
				check_field("final_side_y", want.final_side_y, res_item.final_side_y);
				check_field("steps_taken", 32'(want.steps_taken), 32'(res_item.steps_taken));
			end
		end
	end

	// ---------------------------------------------------------------- command side

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_item(cmd_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		do @(posedge clk); while (!cmd_ready);
		record_transfer(it);
		items_sent++;
	endtask

	// sender pause until every cast has answered; always advances at least one edge
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_walks.size() != 0);
	endtask

	function automatic cmd_item_t random_fields();
		cmd_item_t it;
		it.cmd            = CMD_CAST;
		it.cell_x         = 6'($urandom);
		it.cell_y         = 6'($urandom);
		it.cell_value     = 4'($urandom);
		it.ray_pos_x      = 16'($urandom);
		it.ray_pos_y      = 16'($urandom);
		it.dir_x_negative = 1'($urandom);
		it.dir_y_negative = 1'($urandom);
		it.delta_dist_x   = 24'($urandom);
		it.delta_dist_y   = 24'($urandom);
		return it;
	endfunction

	function automatic cmd_item_t make_ray(logic [15:0] px, logic [15:0] py, logic nx, logic ny,
			logic [23:0] dx, logic [23:0] dy);
		cmd_item_t it;
		it                = random_fields();
		it.ray_pos_x      = px;
		it.ray_pos_y      = py;
		it.dir_x_negative = nx;
		it.dir_y_negative = ny;
		it.delta_dist_x   = dx;
		it.delta_dist_y   = dy;
		return it;
	endfunction

	function automatic logic [3:0] pick_value(int wall_pct);
		logic [3:0] v;
		if ($urandom_range(99) < wall_pct)
			return CELL_WALL;
		do v = 4'($urandom); while (v == CELL_WALL);
		return v;
	endfunction

	task automatic write_cell(int idx, logic [3:0] value);
		cmd_item_t it;
		it            = random_fields();
		it.cmd        = CMD_WRITE;
		it.cell_x     = 6'(idx % MAP_DIM);
		it.cell_y     = 6'(idx / MAP_DIM);
		it.cell_value = value;
		send_item(it);
	endtask

	// fills every never-written cell on the ray's path first, then casts it
	task automatic cast_ray(cmd_item_t ray, int wall_pct);
		res_item_t res;
		int        unknown;
		ray.cmd = CMD_CAST;
		unknown = walk_ray(ray, res);
		while (unknown >= 0) begin
			write_cell(unknown, pick_value(wall_pct));
			unknown = walk_ray(ray, res);
		end
		send_item(ray);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		send_gap_pct = 0;
		stall_pct    = 0;
		// wall right beside the start cell, one x step
		write_cell(3 * MAP_DIM + 5, CELL_WALL);
		cast_ray(make_ray(16'h1200, 16'h0E00, 1'b0, 1'b0, 24'h01_0000, 24'hFF_FFFF), 0);
		// zero deltas tie on the first step: y wins and leaves through row 0
		cast_ray(make_ray(16'h2900, 16'h0200, 1'b0, 1'b1, 24'h00_0000, 24'h00_0000), 0);
		// zero fraction going -x from column 0 leaves at once
		cast_ray(make_ray(16'h0000, 16'h0A00, 1'b1, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF), 0);
		// start cell holds a wall but is never tested; one open cell, then the wall
		write_cell(10 * MAP_DIM + 30, CELL_WALL);
		write_cell(10 * MAP_DIM + 31, 4'd0);
		write_cell(10 * MAP_DIM + 32, CELL_WALL);
		cast_ray(make_ray(16'h7A00, 16'h2A00, 1'b0, 1'b0, 24'h01_0000, 24'hFF_FFFF), 0);
		wait_drained();
	endtask

	// open paths crossing the whole map; on a 64 wide map the longest walk
	// stays inside for 126 steps, so the step limit itself cannot trigger
	task automatic test_long_walks();
		send_gap_pct = 0;
		stall_pct    = 0;
		// equal deltas: tie first, then alternate y and x corner to corner
		cast_ray(make_ray(16'h0000, 16'h0000, 1'b0, 1'b0, 24'h01_0000, 24'h01_0000), 0);
		cast_ray(make_ray(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 24'h01_0000, 24'h01_0000), 0);
		// zero x delta keeps the x side at zero: straight along row 40
		cast_ray(make_ray(16'h0000, 16'hA064, 1'b0, 1'b0, 24'h00_0000, 24'h00_8000), 0);
		// zero y delta: straight down column 20 from the top row
		cast_ray(make_ray(16'h5007, 16'hFFFF, 1'b0, 1'b1, 24'h00_F000, 24'h00_0000), 0);
		wait_drained();
	endtask

	task automatic test_extremes();
		send_gap_pct = 0;
		stall_pct    = 0;
		cast_ray(make_ray(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF), 40);
		cast_ray(make_ray(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 24'hFF_FFFF, 24'h00_0001), 40);
		cast_ray(make_ray(16'h0000, 16'h0000, 1'b0, 1'b0, 24'h00_0001, 24'hFF_FFFF), 40);
		cast_ray(make_ray(16'h8000, 16'h7FFF, 1'b1, 1'b0, 24'h80_0000, 24'h7F_FFFF), 40);
		cast_ray(make_ray(16'h03FF, 16'hFC00, 1'b0, 1'b1, 24'h55_5555, 24'hAA_AAAA), 40);
		wait_drained();
	endtask

	// mostly casts over a growing map, a few stray overwrites
	task automatic test_random_traffic(int count, int gap_pct, int stall);
		cmd_item_t it;
		int        last;
		send_gap_pct = gap_pct;
		stall_pct    = stall;
		last         = items_sent + count;
		while (items_sent < last) begin
			it = random_fields();
			if ($urandom_range(99) < 8) begin
				it.cmd = CMD_WRITE;
				send_item(it);
			end else begin
				case ($urandom_range(4))
					0: ; // full-range deltas
					1: begin
						it.delta_dist_x = 24'($urandom_range(24'h03_0000));
						it.delta_dist_y = 24'($urandom_range(24'h03_0000));
					end
					2: it.delta_dist_y = it.delta_dist_x;
					3: begin
						// one side distance stays put, straight walk
						if ($urandom_range(1))
							it.delta_dist_x = '0;
						else
							it.delta_dist_y = '0;
					end
					default: begin
						// equal fractions and deltas give ties
						it.ray_pos_y[9:0] = it.ray_pos_x[9:0];
						it.delta_dist_y   = it.delta_dist_x;
						it.dir_y_negative = it.dir_x_negative;
					end
				endcase
				cast_ray(it, 12);
			end
		end
		wait_drained();
	endtask

	// receiver holds off long enough that a finished walk waits and cmd_ready drops
	task automatic test_backpressure();
		send_gap_pct = 0;
		stall_pct    = 0;
		hold_request = 8 * WALK_CYCLES;
		repeat (12) cast_ray(random_fields(), 12);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_long_walks();
		test_extremes();
		test_random_traffic(280, 0, 0);
		test_random_traffic(280, 80, 0);
		test_random_traffic(280, 0, 80);
		test_random_traffic(280, 15, 15);
		test_backpressure();
		wait_drained();
		repeat (WALK_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_walks.size() == 0)
			$display("[grid_ray_dda_walker_core] OK");
		else
			$display("[grid_ray_dda_walker_core] ERROR");
		$finish;
	end

endmodule

### filelist.f
src/grdw_pkg.sv
src/grdw_ram.sv
src/grdw_alu.sv
src/grid_ray_dda_walker_core.sv
sim/tb_grid_ray_dda_walker_core.sv
